FILE: rtl/frs_pkg.sv
package frs_pkg;

	typedef logic [2:0] port_t;

	localparam port_t PORT_N    = 3'd0;
	localparam port_t PORT_S    = 3'd1;
	localparam port_t PORT_E    = 3'd2;
	localparam port_t PORT_W    = 3'd3;
	localparam port_t PORT_CORE = 3'd4;
	localparam port_t PORT_NONE = 3'd5;

	typedef logic [1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_TILE_ID    = 2'd0;
	localparam cfg_idx_t CFG_FAULT_MASK = 2'd1;
	localparam cfg_idx_t CFG_ODD_TYPE   = 2'd2;

	localparam int HIST_W = 32;
	localparam logic [2:0] QUAD_MAX = 3'd3;

	// stage 1: flit header plus coordinate compares
	typedef struct packed {
		logic              has_info;
		port_t             in_port;
		logic              src_here;
		logic              dst_here;
		logic [HIST_W-1:0] hist;
		logic              lb;
		logic              lba;
		logic [2:0]        pq;
		logic              dr_gt;
		logic              dr_lt;
		logic              dc_gt;
		logic              dc_lt;
		logic              bn;
		logic              bs;
		logic              bw;
		logic              be;
	} s1_t;

	// stage 2: quadrant and candidate ports
	typedef struct packed {
		logic              has_info;
		logic              src_here;
		logic              dst_here;
		logic [HIST_W-1:0] hist;
		logic              lb;
		logic              lba;
		logic [2:0]        pq;
		logic [1:0]        q;
		port_t             norm;
		port_t             adap;
		logic              nb;
		logic              ab;
		logic              straight;
	} s2_t;

endpackage

FILE: rtl/frs_coord.sv
module frs_coord #(
	parameter int MESH_COLS = 8,
	parameter int MESH_ROWS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 has_info,
	input  frs_pkg::port_t       in_port,
	input  logic [5:0]           source_tile,
	input  logic [5:0]           dest_tile,
	input  logic [31:0]          move_history,
	input  logic                 was_back,
	input  logic                 was_back_adaptive,
	input  logic [2:0]           prev_quadrant,
	input  logic [5:0]           tile_id,
	output logic                 valid_s1,
	output frs_pkg::s1_t         data_s1
);
	import frs_pkg::*;

	logic [5:0] row_lut [64];
	logic [5:0] col_lut [64];
	logic [5:0] hr, hc, dr, dc;
	s1_t        nxt;

	for (genvar g = 0; g < 64; g++) begin : g_lut
		assign row_lut[g] = 6'(g / MESH_COLS);
		assign col_lut[g] = 6'(g % MESH_COLS);
	end

	always_comb begin
		hr = row_lut[tile_id];
		hc = col_lut[tile_id];
		dr = row_lut[dest_tile];
		dc = col_lut[dest_tile];
		nxt.has_info = has_info;
		nxt.in_port  = in_port;
		nxt.src_here = (source_tile == tile_id);
		nxt.dst_here = (dest_tile == tile_id);
		nxt.hist     = move_history;
		nxt.lb       = was_back;
		nxt.lba      = was_back_adaptive;
		nxt.pq       = prev_quadrant;
		nxt.dr_gt    = (dr > hr);
		nxt.dr_lt    = (dr < hr);
		nxt.dc_gt    = (dc > hc);
		nxt.dc_lt    = (dc < hc);
		nxt.bn       = (hr == 6'd0);
		nxt.bs       = (hr == 6'(MESH_ROWS - 1));
		nxt.bw       = (hc == 6'd0);
		nxt.be       = (hc == 6'(MESH_COLS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			data_s1 <= nxt;
		end
	end

endmodule

FILE: rtl/frs_quad.sv
module frs_quad (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         valid_s1,
	input  frs_pkg::s1_t data_s1,
	input  logic [4:0]   fault_mask,
	input  logic         odd_type,
	output logic         valid_s2,
	output frs_pkg::s2_t data_s2
);
	import frs_pkg::*;

	logic [1:0] q;
	port_t      norm, adap;
	logic       straight, row_eq, col_eq;
	s2_t        nxt;

	always_comb begin
		row_eq = !data_s1.dr_gt && !data_s1.dr_lt;
		col_eq = !data_s1.dc_gt && !data_s1.dc_lt;
		if (data_s1.dr_gt) begin
			if (data_s1.dc_gt)      q = 2'd0;
			else if (data_s1.dc_lt) q = 2'd1;
			else                    q = (data_s1.be || data_s1.in_port == PORT_E) ? 2'd1 : 2'd0;
		end else if (data_s1.dr_lt) begin
			if (data_s1.dc_gt)      q = 2'd2;
			else if (data_s1.dc_lt) q = 2'd3;
			else                    q = (data_s1.bw || data_s1.in_port == PORT_W) ? 2'd2 : 2'd3;
		end else if (data_s1.dc_gt) begin
			q = (data_s1.bn || data_s1.in_port == PORT_N) ? 2'd0 : 2'd2;
		end else begin
			q = (data_s1.bs || data_s1.in_port == PORT_S) ? 2'd3 : 2'd1;
		end

		case (q)
			2'd0: begin
				norm     = odd_type ? PORT_E : PORT_S;
				adap     = odd_type ? PORT_S : PORT_E;
				straight = odd_type ? col_eq : row_eq;
			end
			2'd1: begin
				norm     = odd_type ? PORT_S : PORT_W;
				adap     = odd_type ? PORT_W : PORT_S;
				straight = odd_type ? row_eq : col_eq;
			end
			2'd2: begin
				norm     = odd_type ? PORT_N : PORT_E;
				adap     = odd_type ? PORT_E : PORT_N;
				straight = odd_type ? row_eq : col_eq;
			end
			default: begin
				norm     = odd_type ? PORT_W : PORT_N;
				adap     = odd_type ? PORT_N : PORT_W;
				straight = odd_type ? col_eq : row_eq;
			end
		endcase

		nxt.has_info = data_s1.has_info;
		nxt.src_here = data_s1.src_here;
		nxt.dst_here = data_s1.dst_here;
		nxt.hist     = data_s1.hist;
		nxt.lb       = data_s1.lb;
		nxt.lba      = data_s1.lba;
		nxt.pq       = data_s1.pq;
		nxt.q        = q;
		nxt.norm     = norm;
		nxt.adap     = adap;
		nxt.nb       = fault_mask[norm[1:0]] || (norm == data_s1.in_port);
		nxt.ab       = fault_mask[adap[1:0]] || (adap == data_s1.in_port);
		nxt.straight = straight;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			data_s2 <= nxt;
		end
	end

endmodule

FILE: rtl/frs_decide.sv
module frs_decide (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_s2,
	input  frs_pkg::s2_t   data_s2,
	input  logic [4:0]     fault_mask,
	input  logic           odd_type,
	output logic           valid_s3,
	output frs_pkg::port_t next_port_s3,
	output logic [31:0]    hist_s3,
	output logic           lb_s3,
	output logic           lba_s3,
	output logic [2:0]     quad_s3,
	output logic           fail_s3
);
	import frs_pkg::*;

	logic        fwd, fadap, undo_adap, sel;
	port_t       fin, bk, port;
	logic [31:0] hist;
	logic        lb, lba, fail;
	logic [2:0]  quad;

	always_comb begin
		fwd   = 1'b0;
		fadap = 1'b0;
		fin   = PORT_NONE;
		if (data_s2.straight) begin
			if (!data_s2.ab) begin
				fwd = 1'b1; fin = data_s2.adap;
			end else if (!data_s2.nb) begin
				fwd = 1'b1; fadap = 1'b1; fin = data_s2.norm;
			end
			if (data_s2.lb && data_s2.lba) begin
				fwd = !data_s2.nb; fadap = 1'b0; fin = data_s2.norm;
			end
			if (data_s2.lb && !data_s2.lba) fwd = 1'b0;
		end else begin
			if (!data_s2.nb) begin
				fwd = 1'b1; fin = data_s2.norm;
			end else if (!data_s2.ab) begin
				fwd = 1'b1; fadap = 1'b1; fin = data_s2.adap;
			end
			if (data_s2.lb && !data_s2.lba) begin
				fwd = !data_s2.ab; fadap = 1'b1; fin = data_s2.adap;
			end
			if (data_s2.lb && data_s2.lba) fwd = 1'b0;
		end

		// odd tiles flip the adaptive choice of the undo port
		undo_adap = data_s2.hist[0];
		sel       = undo_adap ^ odd_type;
		case (data_s2.pq[1:0])
			2'd0:    bk = sel ? PORT_N : PORT_W;
			2'd1:    bk = sel ? PORT_E : PORT_N;
			2'd2:    bk = sel ? PORT_W : PORT_S;
			default: bk = sel ? PORT_S : PORT_E;
		endcase

		port = PORT_NONE;
		hist = data_s2.hist;
		lb   = data_s2.lb;
		lba  = data_s2.lba;
		quad = {1'b0, data_s2.q};
		fail = 1'b0;
		if (!data_s2.has_info) begin
			quad = data_s2.pq;
		end else if (data_s2.dst_here) begin
			if (fault_mask[PORT_CORE]) fail = 1'b1;
			else                       port = PORT_CORE;
		end else if (fwd) begin
			lb   = 1'b0;
			port = fin;
			hist = {data_s2.hist[30:0], fadap};
			fail = data_s2.hist[31];
		end else begin
			lb = 1'b1;
			if (data_s2.src_here || data_s2.pq > QUAD_MAX || fault_mask[bk[1:0]]) begin
				fail = 1'b1;
			end else begin
				port = bk;
				lba  = undo_adap;
				hist = {1'b0, data_s2.hist[31:1]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			next_port_s3 <= port;
			hist_s3      <= hist;
			lb_s3        <= lb;
			lba_s3       <= lba;
			quad_s3      <= quad;
			fail_s3      <= fail;
		end
	end

endmodule

FILE: rtl/fault_tolerant_mesh_route_select_unit.sv
// channel   signals                                          transfer when
// command   start, busy, has_info .. prev_quadrant           start && !busy
// result    done, next_port .. route_fail                    done (one cycle)
// config    cfg_we, cfg_idx, cfg_wdata                       cfg_we
//
// one flit header enters per cycle; busy is always low
// done and the result are registered through the stages coordinate lookup, quadrant
// and port pick, and forward or backtrack decision
// reset clears tile_id, fault_mask, odd_type and the stage valid bits
// the result side cannot stall, so the pipeline never holds
module fault_tolerant_mesh_route_select_unit #(
	parameter int MESH_COLS = 8,
	parameter int MESH_ROWS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                has_info,
	input  frs_pkg::port_t      in_port,
	input  logic [5:0]          source_tile,
	input  logic [5:0]          dest_tile,
	input  logic [31:0]         move_history,
	input  logic                was_back,
	input  logic                was_back_adaptive,
	input  logic [2:0]          prev_quadrant,
	output logic                done,
	output frs_pkg::port_t      next_port,
	output logic [31:0]         new_history,
	output logic                new_was_back,
	output logic                new_was_back_adaptive,
	output logic [2:0]          new_quadrant,
	output logic                route_fail,
	input  logic                cfg_we,
	input  frs_pkg::cfg_idx_t   cfg_idx,
	input  logic [5:0]          cfg_wdata
);
	import frs_pkg::*;

	logic [5:0] tile_id_q;
	logic [4:0] fault_mask_q;
	logic       odd_type_q;
	logic       valid_s1, valid_s2;
	s1_t        data_s1;
	s2_t        data_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_id_q    <= '0;
			fault_mask_q <= '0;
			odd_type_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_TILE_ID:    tile_id_q    <= cfg_wdata;
				CFG_FAULT_MASK: fault_mask_q <= cfg_wdata[4:0];
				CFG_ODD_TYPE:   odd_type_q   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	frs_coord #(
		.MESH_COLS (MESH_COLS),
		.MESH_ROWS (MESH_ROWS)
	) u_coord (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (start && !busy),
		.has_info          (has_info),
		.in_port           (in_port),
		.source_tile       (source_tile),
		.dest_tile         (dest_tile),
		.move_history      (move_history),
		.was_back          (was_back),
		.was_back_adaptive (was_back_adaptive),
		.prev_quadrant     (prev_quadrant),
		.tile_id           (tile_id_q),
		.valid_s1          (valid_s1),
		.data_s1           (data_s1)
	);

	frs_quad u_quad (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.data_s1    (data_s1),
		.fault_mask (fault_mask_q),
		.odd_type   (odd_type_q),
		.valid_s2   (valid_s2),
		.data_s2    (data_s2)
	);

	frs_decide u_decide (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s2     (valid_s2),
		.data_s2      (data_s2),
		.fault_mask   (fault_mask_q),
		.odd_type     (odd_type_q),
		.valid_s3     (done),
		.next_port_s3 (next_port),
		.hist_s3      (new_history),
		.lb_s3        (new_was_back),
		.lba_s3       (new_was_back_adaptive),
		.quad_s3      (new_quadrant),
		.fail_s3      (route_fail)
	);

endmodule
